### design/lii_pkg.sv
// Package for the live interval interference block.
// Holds the sizing constants, the stream layout and the item kind codes.
// No dependencies.
package lii_pkg;

    localparam int MAX_VALUES   = 64;
    localparam int MAX_POSITION = 4095;

    localparam int IDX_W = $clog2(MAX_VALUES);
    localparam int POS_W = $clog2(MAX_POSITION + 1);
    localparam int VID_W = 6;
    localparam int NB_W  = 64;
    localparam int OP_W  = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 72;

    localparam logic [OP_W-1:0] OP_INSN   = 2'd0;
    localparam logic [OP_W-1:0] OP_USE    = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

endpackage

### design/live_interval_interference_top.sv
// Live interval interference block: tracks value intervals over a basic block
// and emits one neighbour row per tracked value on a finish transaction, or a
// single row marked invalid when no value is tracked. Depends on lii_pkg.
//
//  channel  dir  tdata (low bit up)                      tuser          tlast
//  s        in   has_result[0], value_id[6:1], 0 pad     opcode[1:0]    -
//  m        out  row_value[5:0], neighbours[69:6], 0 pad row_valid[0]   last
//
// Instruction and use transactions are taken one per cycle while the block is
// idle. A finish walks the value indices one per cycle; every tracked value then
// scans all indices through the second read port of the interval memories and
// then waits for its row to be taken. Input is held off during the whole finish
// pass. Reset is synchronous and clears the tracked flags and position; interval
// memories are not reset.
module live_interval_interference_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // has_result, value_id, zero padding
    input  logic [lii_pkg::S_DATA_W-1:0]   i_s_tdata,
    // opcode
    input  logic [lii_pkg::OP_W-1:0]       i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // row_value, neighbours, zero padding
    output logic [lii_pkg::M_DATA_W-1:0]   o_m_tdata,
    // row_valid
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import lii_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SELA  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VALUES - 1);

    logic [POS_W-1:0] mem_start [MAX_VALUES];
    logic [POS_W-1:0] mem_end   [MAX_VALUES];

    logic [2:0]            r_state, n_state;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [MAX_VALUES-1:0] r_tracked, n_tracked;
    logic [IDX_W-1:0]      r_a, n_a;
    logic [IDX_W-1:0]      r_b, n_b;
    logic [IDX_W-1:0]      r_pb, n_pb;
    logic                  r_pv, n_pv;
    logic [MAX_VALUES-1:0] r_mask, n_mask;
    logic                  r_last, n_last;
    logic [POS_W-1:0]      r_sa, r_ea, r_sb, r_eb;

    logic                  s_acc, m_acc;
    logic [OP_W-1:0]       in_op;
    logic                  in_def;
    logic [VID_W-1:0]      in_vid;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_range;
    logic [POS_W-1:0]      pos_inc;
    logic                  wr_start, wr_end;
    logic [POS_W-1:0]      wr_pos;
    logic                  hit;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign m_acc    = o_m_tvalid && i_m_tready;
    assign in_op    = i_s_tuser;
    assign in_def   = i_s_tdata[0];
    assign in_vid   = i_s_tdata[VID_W:1];
    assign in_idx   = in_vid[IDX_W-1:0];
    assign in_range = {1'b0, in_vid} < (VID_W + 1)'(MAX_VALUES);
    assign pos_inc  = (r_pos < POS_W'(MAX_POSITION)) ? r_pos + 1'b1 : r_pos;

    // Overlap test of the held row against the value read in the previous cycle.
    assign hit = r_pv && (r_pb != r_a) && r_tracked[r_pb] &&
                 (r_sa <= r_eb) && (r_sb <= r_ea);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_tracked = r_tracked;
        n_a       = r_a;
        n_b       = r_b;
        n_pb      = r_pb;
        n_pv      = r_pv;
        n_mask    = r_mask;
        n_last    = r_last;
        wr_start  = 1'b0;
        wr_end    = 1'b0;
        wr_pos    = pos_inc;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_INSN: begin
                            n_pos = pos_inc;
                            if (in_def && in_range) begin
                                n_tracked[in_idx] = 1'b1;
                                wr_start = 1'b1;
                                wr_end   = 1'b1;
                            end
                        end
                        OP_USE: begin
                            wr_pos = r_pos;
                            if (in_range && r_tracked[in_idx]) begin
                                wr_end = 1'b1;
                            end
                        end
                        OP_FINISH: begin
                            n_a = '0;
                            if (|r_tracked) begin
                                n_state = S_SELA;
                            end else begin
                                n_state = S_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SELA: begin
                // A tracked row is always found: the last flag stops the walk.
                if (r_tracked[r_a]) begin
                    n_b     = '0;
                    n_pv    = 1'b0;
                    n_mask  = '0;
                    n_state = S_SCAN;
                end else begin
                    n_a = r_a + 1'b1;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_mask[r_pb] = 1'b1;
                end
                n_pv = 1'b1;
                n_pb = r_b;
                if (r_b == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            S_DRAIN: begin
                if (hit) begin
                    n_mask[r_pb] = 1'b1;
                end
                n_pv    = 1'b0;
                n_last  = ~|((r_tracked >> r_a) >> 1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (m_acc) begin
                    if (r_last) begin
                        n_tracked = '0;
                        n_pos     = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_a     = r_a + 1'b1;
                        n_state = S_SELA;
                    end
                end
            end
            S_EMPTY: begin
                if (m_acc) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_tracked <= '0;
            r_pv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_tracked <= n_tracked;
            r_pv      <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_pb   <= n_pb;
        r_mask <= n_mask;
        r_last <= n_last;
    end

    // Interval memories: one write port, reads at the row and the scan index.
    always_ff @(posedge i_clk) begin
        if (wr_start) begin
            mem_start[in_idx] <= wr_pos;
        end
        if (wr_end) begin
            mem_end[in_idx] <= wr_pos;
        end
        r_sa <= mem_start[r_a];
        r_ea <= mem_end[r_a];
        r_sb <= mem_start[r_b];
        r_eb <= mem_end[r_b];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_EMIT) || (r_state == S_EMPTY);
    assign o_m_tuser  = (r_state == S_EMIT);
    assign o_m_tlast  = (r_state == S_EMPTY) || r_last;

    always_comb begin
        o_m_tdata = '0;
        if (r_state == S_EMIT) begin
            o_m_tdata[VID_W-1:0]          = VID_W'(r_a);
            o_m_tdata[VID_W+NB_W-1:VID_W] = NB_W'(r_mask);
        end
    end

endmodule

### verif/interference_row_checker.sv
// Checker for the live interval interference block: watches both stream channels,
// predicts the interference rows and compares every row taken from the block.
// Depends on lii_pkg.
module interference_row_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // has_result, value_id, zero padding
    input  logic [lii_pkg::S_DATA_W-1:0]  i_s_tdata,
    // opcode
    input  logic [lii_pkg::OP_W-1:0]      i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // row_value, neighbours, zero padding
    input  logic [lii_pkg::M_DATA_W-1:0]  i_m_tdata,
    // row_valid
    input  logic                          i_m_tuser,
    input  logic                          i_m_tlast,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lii_pkg::*;

    typedef struct packed {
        logic [VID_W-1:0] value;
        logic [NB_W-1:0]  neighbours;
        logic             valid;
        logic             last;
    } t_irow;

    logic [POS_W-1:0]      live_start [MAX_VALUES];
    logic [POS_W-1:0]      live_end   [MAX_VALUES];
    logic [MAX_VALUES-1:0] live_tracked;
    logic [POS_W-1:0]      live_pos;
    t_irow                 rows_awaited [$];

    // Every tracked pair is compared; an empty block still yields one row marked invalid.
    function automatic void build_interference_rows();
        logic [NB_W-1:0] mask;
        int count;
        t_irow row;
        count = 0;
        for (int a = 0; a < MAX_VALUES; a++) begin
            if (live_tracked[a]) begin
                mask = '0;
                for (int b = 0; b < MAX_VALUES; b++) begin
                    if (b != a && live_tracked[b] && live_start[a] <= live_end[b]
                            && live_start[b] <= live_end[a])
                        mask[b] = 1'b1;
                end
                row = '{value: VID_W'(a), neighbours: mask, valid: 1'b1, last: 1'b0};
                rows_awaited.insert(rows_awaited.size(), row);
                count++;
            end
        end
        if (count == 0) begin
            row = '{value: '0, neighbours: '0, valid: 1'b0, last: 1'b1};
            rows_awaited.insert(rows_awaited.size(), row);
        end else
            rows_awaited[rows_awaited.size() - 1].last = 1'b1;
        live_tracked = '0;
        live_pos = '0;
    endfunction

    function automatic void apply_item(logic [OP_W-1:0] op, logic defines,
                                       logic [VID_W-1:0] vid);
        case (op)
            OP_INSN: begin
                if (live_pos != POS_W'(MAX_POSITION))
                    live_pos = live_pos + 1'b1;
                if (defines) begin
                    live_tracked[vid] = 1'b1;
                    live_start[vid] = live_pos;
                    live_end[vid] = live_pos;
                end
            end
            OP_USE: begin
                if (live_tracked[vid])
                    live_end[vid] = live_pos;
            end
            OP_FINISH: build_interference_rows();
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_irow seen;
        t_irow want;
        if (!i_rst_n) begin
            live_tracked = '0;
            live_pos = '0;
            rows_awaited.delete();
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                apply_item(i_s_tuser, i_s_tdata[0], i_s_tdata[VID_W:1]);
            if (i_m_tvalid && i_m_tready) begin
                seen = '{value: i_m_tdata[VID_W-1:0], neighbours: i_m_tdata[VID_W +: NB_W],
                         valid: i_m_tuser, last: i_m_tlast};
                if (rows_awaited.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display({"%0t: unexpected row: value %0d neighbours %h ",
                                  "valid %0d last %0d"},
                                 $time, seen.value, seen.neighbours, seen.valid, seen.last);
                end else begin
                    want = rows_awaited.pop_front();
                    if (seen !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: row mismatch: expected value %0d neighbours %h ",
                                      "valid %0d last %0d, got value %0d neighbours %h ",
                                      "valid %0d last %0d"}, $time,
                                     want.value, want.neighbours, want.valid, want.last,
                                     seen.value, seen.neighbours, seen.valid, seen.last);
                    end
                end
            end
        end
        o_pending = rows_awaited.size();
    end

endmodule

### verif/testbench.sv
// Top of the testbench for the live interval interference block: clock, reset,
// basic-block stimulus, receiver back-pressure, watchdog and the verdict.
// Depends on lii_pkg, live_interval_interference_top and interference_row_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lii_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = OP_INSN;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int row_failures;
    int rows_outstanding;
    int items_sent = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int rx_gap = 0;

    always #10 clk = ~clk;

    live_interval_interference_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    interference_row_checker rows_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (row_failures),
        .o_pending    (rows_outstanding)
    );

    // Mostly back-to-back, some short gaps and the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic defines, logic [VID_W-1:0] vid);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, vid, defines};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_finish();
        send_item(OP_FINISH, 1'($urandom_range(0, 1)), VID_W'($urandom_range(0, 63)));
    endtask

    // The transaction just taken must not stay on offer while the sender waits.
    task automatic wait_rows_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rows_outstanding != 0) @(negedge clk);
    endtask

    // A block over a small pool of values: mostly defines and uses of the pool,
    // with some plain instructions, stray uses and spare-opcode transactions mixed in.
    task automatic random_block(int n_vals, int steps, bit stall_receiver);
        logic [VID_W-1:0] pool [$];
        bit               taken [MAX_VALUES];
        logic [VID_W-1:0] v;
        int               r;
        while (pool.size() < n_vals) begin
            v = VID_W'($urandom_range(0, MAX_VALUES - 1));
            if (!taken[v]) begin
                taken[v] = 1'b1;
                pool.insert(pool.size(), v);
            end
        end
        repeat (steps) begin
            r = $urandom_range(0, 99);
            v = pool[$urandom_range(0, pool.size() - 1)];
            if (r < 45)
                send_item(OP_INSN, 1'b1, v);
            else if (r < 55)
                send_item(OP_INSN, 1'b0, VID_W'($urandom_range(0, 63)));
            else if (r < 92)
                send_item(OP_USE, 1'($urandom_range(0, 1)), v);
            else if (r < 96)
                send_item(OP_USE, 1'($urandom_range(0, 1)), VID_W'($urandom_range(0, 63)));
            else
                send_item(OP_SPARE, 1'($urandom_range(0, 1)), VID_W'($urandom_range(0, 63)));
        end
        if (stall_receiver)
            hold_requests++;
        send_finish();
    endtask

    // Every value defined once in shuffled order, with uses of already defined ones in between.
    task automatic full_block();
        int order [MAX_VALUES];
        int j;
        int t;
        for (int i = 0; i < MAX_VALUES; i++)
            order[i] = i;
        for (int i = MAX_VALUES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < MAX_VALUES; i++) begin
            send_item(OP_INSN, 1'b1, VID_W'(order[i]));
            if ($urandom_range(0, 2) == 0)
                send_item(OP_USE, 1'($urandom_range(0, 1)), VID_W'(order[$urandom_range(0, i)]));
        end
        send_finish();
    endtask

    // The receiver keeps its own count for a long hold once one is asked for.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_gap <= pick_gap();
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int random_start;
        int blk;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Empty block first, then defines, uses, a redefinition, untracked and
        // ignored transactions, and a finish straight after a finish.
        send_finish();
        send_item(OP_INSN, 1'b1, 6'd0);
        send_item(OP_INSN, 1'b1, 6'd63);
        send_item(OP_USE, 1'b0, 6'd0);
        send_item(OP_INSN, 1'b0, 6'd42);
        send_item(OP_USE, 1'b0, 6'd63);
        send_item(OP_USE, 1'b0, 6'd5);
        send_item(OP_SPARE, 1'b1, 6'd21);
        send_item(OP_USE, 1'b1, 6'd0);
        send_item(OP_INSN, 1'b1, 6'd0);
        send_item(OP_INSN, 1'b1, 6'd21);
        send_item(OP_INSN, 1'b1, 6'd42);
        send_item(OP_USE, 1'b0, 6'd21);
        send_item(OP_FINISH, 1'b1, 6'd63);
        send_item(OP_FINISH, 1'b0, 6'd0);
        wait_rows_drained();

        random_start = items_sent;
        blk = 0;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (blk == 6)
                full_block();
            else if (blk == 3)
                random_block(12, 40, 1'b1);
            else if ($urandom_range(0, 9) == 0)
                random_block($urandom_range(20, 40), $urandom_range(30, 60), 1'b0);
            else
                random_block($urandom_range(1, 10), $urandom_range(3, 30), 1'b0);
            if (blk % 7 == 5)
                wait_rows_drained();
            blk++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_rows_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (row_failures == 0 && rows_outstanding == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### files.f
design/lii_pkg.sv
design/live_interval_interference_top.sv
verif/interference_row_checker.sv
verif/testbench.sv
